FILE: rtl/pac_pkg.sv
// ----------------------------------------------------------------------------
// PID angle controller package
// Shared widths, reset values, register indexes and beat types.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int CHANNELS_DEF = 3;

  localparam int CH_W      = 2;
  localparam int ANGLE_W   = 20;
  localparam int ERR_W     = 21;
  localparam int INTEG_W   = 20;
  localparam int DERIV_W   = 22;
  localparam int GAIN_W    = 20;
  localparam int LIMIT_W   = 19;
  localparam int TORQUE_W  = 24;
  localparam int FRAC_SHIFT = 20;

  localparam int FIFO_DEPTH = 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(52429);
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(1049);
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(10486);
  localparam logic [LIMIT_W-1:0] LIMIT_RST      = LIMIT_W'(12800);

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [1:0] REG_LIMIT      = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [ANGLE_W-1:0] measured_angle;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]            torque_channel;
    logic signed [TORQUE_W-1:0] torque_command;
    logic                       bad_channel;
  } out_t;

  // Controller terms handed from the state update to the torque datapath.
  typedef struct packed {
    logic                      vld;
    logic [CH_W-1:0]           ch;
    logic                      bad;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } terms_t;

endpackage

FILE: rtl/pac_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pac_torque.sv
// ----------------------------------------------------------------------------
// Torque datapath
// Three gain multiplies, a registered sum, floor shift and saturation.
// ----------------------------------------------------------------------------
module pac_torque import pac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  terms_t            terms,
  input  logic [GAIN_W-1:0] kp,
  input  logic [GAIN_W-1:0] ki,
  input  logic [GAIN_W-1:0] kd,
  output logic              res_vld,
  output out_t              res
);

  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int PI_W  = GAIN_W + 1 + INTEG_W;
  localparam int PD_W  = GAIN_W + 1 + DERIV_W;
  localparam int SUM_W = PD_W + 2;
  localparam int SH_W  = SUM_W - FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] SH_MAX = SH_W'((2 ** (TORQUE_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SH_MIN = -SH_W'(2 ** (TORQUE_W - 1));

  logic signed [PP_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [PP_W-1:0]  prod_p_r;
  logic signed [PI_W-1:0]  prod_i_r;
  logic signed [PD_W-1:0]  prod_d_r;
  logic                    a_vld_r;
  logic [CH_W-1:0]         a_ch_r;
  logic                    a_bad_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic                    b_vld_r;
  logic [CH_W-1:0]         b_ch_r;
  logic                    b_bad_r;
  logic signed [SH_W-1:0]  shifted;
  logic signed [TORQUE_W-1:0] torque;

  assign prod_p = $signed({1'b0, kp}) * terms.err;
  assign prod_i = $signed({1'b0, ki}) * terms.integ;
  assign prod_d = $signed({1'b0, kd}) * terms.deriv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= terms.vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_p_r <= prod_p;
    prod_i_r <= prod_i;
    prod_d_r <= prod_d;
    a_ch_r   <= terms.ch;
    a_bad_r  <= terms.bad;
    sum_r    <= sum_nxt;
    b_ch_r   <= a_ch_r;
    b_bad_r  <= a_bad_r;
  end

  assign sum_nxt = SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);

  // Dropping the low fraction bits of a two's complement value is a floor.
  assign shifted = sum_r[SUM_W-1:FRAC_SHIFT];

  always_comb begin
    if (b_bad_r) begin
      torque = '0;
    end else if (shifted > SH_MAX) begin
      torque = SH_MAX[TORQUE_W-1:0];
    end else if (shifted < SH_MIN) begin
      torque = SH_MIN[TORQUE_W-1:0];
    end else begin
      torque = shifted[TORQUE_W-1:0];
    end
  end

  assign res_vld            = b_vld_r;
  assign res.torque_channel = b_ch_r;
  assign res.torque_command = torque;
  assign res.bad_channel    = b_bad_r;

endmodule

FILE: rtl/pid_angle_controller_three_channel.sv
// ----------------------------------------------------------------------------
// Three-channel PID angle controller
// A beat passes the accept, update, product and sum registers, then the queue.
// Throughput: one input beat per cycle while in_stall is low.
// Reset: rst_n clears gains to defaults, integrals and previous errors to zero.
// ----------------------------------------------------------------------------
module pid_angle_controller_three_channel import pac_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // The per-channel state (integral and previous error) lives in one RAM
  // entry per channel. An accepted beat reads its entry at the accept edge,
  // the next cycle computes the new integral and derivative and writes the
  // entry back. A beat that directly follows one for the same channel reads
  // stale data, so the write-back values held in the next stage are forwarded.

  localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_W     = INTEG_W + ERR_W;
  localparam int ISUM_W   = INTEG_W + 2;
  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int OCC_W    = $clog2(FIFO_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes
  // without wait states.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]  prop_gain_r;
  logic [GAIN_W-1:0]  integ_gain_r;
  logic [GAIN_W-1:0]  deriv_gain_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      limit_r      <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= pwdata[GAIN_W-1:0];
        REG_LIMIT:      limit_r      <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  prdata = CFG_DATA_W'(prop_gain_r);
      REG_INTEG_GAIN: prdata = CFG_DATA_W'(integ_gain_r);
      REG_DERIV_GAIN: prdata = CFG_DATA_W'(deriv_gain_r);
      REG_LIMIT:      prdata = CFG_DATA_W'(limit_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The pipeline never stalls; instead, in_stall rises once the
  // number of beats in flight plus those waiting in the output queue reaches
  // the queue depth, so every accepted beat has a queue slot reserved.
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic             out_pop;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  assign in_stall = (occ_r == OCC_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!in_acc && out_pop) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: look up the state entry and form the error.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]           in_addr;
  logic                    in_bad;
  logic [CHANNELS-1:0]     ent_vld_r;
  logic                    s1_vld_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic                    s1_bad_r;
  logic signed [ERR_W-1:0] s1_err_r;
  logic                    s1_rdok_r;
  logic [ST_W-1:0]         st_rdata;
  logic                    st_we;
  logic [AW-1:0]           st_waddr;
  logic [ST_W-1:0]         st_wdata;

  assign in_addr = AW'(in_data.channel);
  assign in_bad  = (int'(in_data.channel) >= CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch_r   <= in_data.channel;
    s1_bad_r  <= in_bad;
    s1_err_r  <= ERR_W'(in_data.target_angle) - ERR_W'(in_data.measured_angle);
    // Entries never written since reset read as zero.
    s1_rdok_r <= !in_bad && ent_vld_r[in_addr];
  end

  pac_ram #(
    .WIDTH (ST_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (in_addr),
    .rdata (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Update stage: forward, accumulate, clamp, differentiate and write back.
  // ---------------------------------------------------------------------------
  terms_t                     s2_r;
  terms_t                     s2_nxt;
  logic                       fwd;
  logic signed [INTEG_W-1:0]  cur_integ;
  logic signed [ERR_W-1:0]    cur_prev;
  logic signed [ISUM_W-1:0]   integ_sum;
  logic signed [ISUM_W-1:0]   lim_pos;
  logic signed [ISUM_W-1:0]   lim_neg;
  logic signed [INTEG_W-1:0]  integ_new;

  // The preceding beat wrote its entry at the same edge this one read it.
  assign fwd = s2_r.vld && !s2_r.bad && (s2_r.ch == s1_ch_r);

  always_comb begin
    if (fwd) begin
      cur_integ = s2_r.integ;
      cur_prev  = s2_r.err;
    end else if (s1_rdok_r) begin
      cur_integ = st_rdata[ST_W-1:ERR_W];
      cur_prev  = st_rdata[ERR_W-1:0];
    end else begin
      cur_integ = '0;
      cur_prev  = '0;
    end
  end

  assign integ_sum = ISUM_W'(cur_integ) + ISUM_W'(s1_err_r);
  assign lim_pos   = $signed({{(ISUM_W - LIMIT_W){1'b0}}, limit_r});
  assign lim_neg   = -lim_pos;

  // The clamp is applied on every update, so a value stored under an older,
  // wider limit is pulled in on the channel's next beat.
  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_new = lim_pos[INTEG_W-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_new = lim_neg[INTEG_W-1:0];
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
  end

  assign st_we    = s1_vld_r && !s1_bad_r;
  assign st_waddr = AW'(s1_ch_r);
  assign st_wdata = {integ_new, s1_err_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (st_we) begin
      ent_vld_r[st_waddr] <= 1'b1;
    end
  end

  always_comb begin
    s2_nxt.vld   = s1_vld_r;
    s2_nxt.ch    = s1_ch_r;
    s2_nxt.bad   = s1_bad_r;
    s2_nxt.err   = s1_err_r;
    s2_nxt.integ = integ_new;
    s2_nxt.deriv = DERIV_W'(s1_err_r) - DERIV_W'(cur_prev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Torque datapath: multiplies, sum, shift and saturate.
  // ---------------------------------------------------------------------------
  logic res_vld;
  out_t res;

  pac_torque u_torque (
    .clk     (clk),
    .rst_n   (rst_n),
    .terms   (s2_r),
    .kp      (prop_gain_r),
    .ki      (integ_gain_r),
    .kd      (deriv_gain_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // ---------------------------------------------------------------------------
  // Output queue. It decouples the result side, so results keep draining into
  // it while out_stall is high, and new beats are taken until in_stall rises.
  // ---------------------------------------------------------------------------
  out_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [OCC_W-1:0]   fifo_cnt_r;

  assign out_valid = (fifo_cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (res_vld && !out_pop) begin
        fifo_cnt_r <= fifo_cnt_r + 1'b1;
      end else if (!res_vld && out_pop) begin
        fifo_cnt_r <= fifo_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

endmodule

FILE: rtl/pac_checker.sv
// ----------------------------------------------------------------------------
// PID angle controller checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pac_checker import pac_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_t                   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_t                  out_data,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata,
  input logic                  pready
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An invalid channel gives zero torque.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_channel |-> out_data.torque_command == '0)
    else $error("nonzero torque on invalid channel");

  // The flag matches the echoed channel number.
  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bad_channel == (int'(out_data.torque_channel) >= CHANNELS))
    else $error("bad_channel disagrees with channel number");

  // Nothing is offered right after reset.
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind pid_angle_controller_three_channel pac_checker #(.CHANNELS(CHANNELS)) u_pac_checker (.*);
